// ===== design/assert_macros.svh =====
// assertion helper macros for the design folder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a implies b at the same edge
`define ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// a implies b at the next edge
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

// ===== design/socc_pkg.sv =====
// ----------------------------------------------------------------------------
// socc_pkg
// shared types and codes for the segment obstacle collision check
// ----------------------------------------------------------------------------
package socc_pkg;
    localparam int COORD_W = 16;
    localparam int EDGE_W  = 12;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_OUTSIDE = 2'd1;
    localparam t_status ST_CROSS   = 2'd2;
    localparam t_status ST_INSIDE  = 2'd3;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_AREA_W = 2'd0;
    localparam t_cfg_idx CFG_AREA_H = 2'd1;
    localparam t_cfg_idx CFG_COUNT  = 2'd2;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_CHECK = 1'b1;
endpackage

// ===== design/socc_ram.sv =====
// ----------------------------------------------------------------------------
// socc_ram
// generic simple dual port ram (one write port, one read port) with registered read
// ----------------------------------------------------------------------------
module socc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/segment_obstacle_collision_check_top.sv =====
// a load goes straight to its result; a query walks each obstacle in turn: ram
// read, edge setup, four line tests of six products and one eval each, then the
// containment test; it stops at the first crossing or containment
// throughput: one request at a time, the next is taken once the result leaves
// reset: synchronous active low, area registers go to 4095, count to 0;
// the obstacle table is undefined until written
// ----------------------------------------------------------------------------
// segment_obstacle_collision_check_top
// checks a path segment against a table of rectangular obstacles
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module segment_obstacle_collision_check_top #(
    parameter int MAX_OBSTACLES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data,
    // request channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_func,
    input  logic [4:0]  i_slot,
    input  logic [11:0] i_rect_left,
    input  logic [11:0] i_rect_right,
    input  logic [11:0] i_rect_top,
    input  logic [11:0] i_rect_bottom,
    input  logic [15:0] i_start_x,
    input  logic [15:0] i_start_y,
    input  logic [15:0] i_end_x,
    input  logic [15:0] i_end_y,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [4:0]  o_blocking_slot
);
    import socc_pkg::*;

    localparam int AW  = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
    localparam int CW  = $clog2(MAX_OBSTACLES + 1);
    localparam int SW  = 18;     // signed coordinate difference width
    localparam int PW  = 2 * SW; // product width
    localparam int DW  = PW + 1; // cross product width

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_LINE = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_EVAL = 3'd4;
    localparam logic [2:0] S_CONT = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    // configuration registers, always ready; writes must come only when idle, which the block does not enforce
    logic [11:0] r_area_w, r_area_h;
    logic [5:0]  r_count;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area_w <= 12'd4095;
            r_area_h <= 12'd4095;
            r_count  <= 6'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_AREA_W: r_area_w <= i_cfg_data;
                CFG_AREA_H: r_area_h <= i_cfg_data;
                CFG_COUNT:  r_count  <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // limit the walk to the table depth
    logic [CW-1:0] w_limit;
    assign w_limit = (32'(r_count) > MAX_OBSTACLES) ? CW'(MAX_OBSTACLES)
                                                     : CW'(r_count);

    // obstacle table: ordered edges l, r, b, t
    logic            w_we;
    logic [AW-1:0]   w_waddr, r_idx;
    logic [47:0]     w_wdata, w_rdata;
    logic [11:0]     w_lo_x, w_hi_x, w_lo_y, w_hi_y;
    assign w_lo_x = (i_rect_left < i_rect_right) ? i_rect_left : i_rect_right;
    assign w_hi_x = (i_rect_left < i_rect_right) ? i_rect_right : i_rect_left;
    assign w_lo_y = (i_rect_top < i_rect_bottom) ? i_rect_top : i_rect_bottom;
    assign w_hi_y = (i_rect_top < i_rect_bottom) ? i_rect_bottom : i_rect_top;
    assign w_wdata = {w_lo_x, w_hi_x, w_lo_y, w_hi_y};
    assign w_waddr = AW'(i_slot);
    assign w_we = i_valid && o_ready && (i_func == FUNC_LOAD)
                  && (32'(i_slot) < MAX_OBSTACLES);

    socc_ram #(.WIDTH(48), .DEPTH(2 ** AW)) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    // sequencer and data registers
    logic [2:0]    r_state, n_state;
    logic [15:0]   r_sx, r_sy, r_ex, r_ey;
    logic [15:0]   r_l, r_r, r_b, r_t, r_mx, r_my;
    logic [CW-1:0] r_cnt;
    logic [1:0]    r_line;
    logic signed [DW-1:0] r_den, r_sn, r_acc;
    logic signed [PW-1:0] r_prod;
    logic [1:0]    r_status;
    logic [4:0]    r_bslot;
    logic          r_ovalid;

    // line endpoints for the current test: diag up, diag down, mid y, mid x
    logic [15:0] w_ax, w_ay, w_bx, w_by;
    always_comb begin
        case (r_line)
            2'd0: begin w_ax = r_l;  w_ay = r_b;  w_bx = r_r;  w_by = r_t;  end
            2'd1: begin w_ax = r_l;  w_ay = r_t;  w_bx = r_r;  w_by = r_b;  end
            2'd2: begin w_ax = r_l;  w_ay = r_my; w_bx = r_r;  w_by = r_my; end
            default: begin w_ax = r_mx; w_ay = r_b; w_bx = r_mx; w_by = r_t; end
        endcase
    end

    logic signed [SW-1:0] w_ux, w_uy, w_vx, w_vy, w_wx, w_wy;
    assign w_ux = SW'(signed'({2'b0, w_bx})) - SW'(signed'({2'b0, w_ax}));
    assign w_uy = SW'(signed'({2'b0, w_by})) - SW'(signed'({2'b0, w_ay}));
    assign w_vx = SW'(signed'({2'b0, r_ex})) - SW'(signed'({2'b0, r_sx}));
    assign w_vy = SW'(signed'({2'b0, r_ey})) - SW'(signed'({2'b0, r_sy}));
    assign w_wx = SW'(signed'({2'b0, w_ax})) - SW'(signed'({2'b0, r_sx}));
    assign w_wy = SW'(signed'({2'b0, w_ay})) - SW'(signed'({2'b0, r_sy}));

    // shared multiplier: six products in sequence
    // step 0 ux*vy, 1 vx*uy, 2 ux*wy, 3 uy*wx, 4 vx*wy, 5 vy*wx
    logic [2:0] r_pidx;
    logic signed [SW-1:0] w_ma, w_mb;
    always_comb begin
        case (r_pidx)
            3'd0: begin w_ma = w_ux; w_mb = w_vy; end
            3'd1: begin w_ma = w_vx; w_mb = w_uy; end
            3'd2: begin w_ma = w_ux; w_mb = w_wy; end
            3'd3: begin w_ma = w_uy; w_mb = w_wx; end
            3'd4: begin w_ma = w_vx; w_mb = w_wy; end
            default: begin w_ma = w_vy; w_mb = w_wx; end
        endcase
    end

    // sign-aware range test of the accumulated numerators
    // at eval r_acc holds vx*wy and r_prod holds vy*wx; tn is finished here
    logic signed [DW-1:0] w_tn, w_den_a, w_sn_a, w_tn_a;
    logic                 w_neg, w_hit;
    assign w_tn    = r_acc - DW'(r_prod);
    assign w_neg   = r_den < 0;
    assign w_den_a = w_neg ? -r_den : r_den;
    assign w_sn_a  = w_neg ? -r_sn : r_sn;
    assign w_tn_a  = w_neg ? -w_tn : w_tn;
    assign w_hit   = (r_den != 0) && (w_sn_a >= 0) && (w_sn_a <= w_den_a)
                     && (w_tn_a >= 0) && (w_tn_a <= w_den_a);

    logic w_inside;
    assign w_inside = (r_ex >= r_l) && (r_ex <= r_r) && (r_ey >= r_b) && (r_ey <= r_t);

    logic w_outside;
    assign w_outside = (i_end_x > {r_area_w, 4'b0}) || (i_end_y > {r_area_h, 4'b0});

    // midlines from whole-pixel edges, integer half
    logic [12:0] w_sum_x, w_sum_y;
    assign w_sum_x = {1'b0, w_rdata[47:36]} + {1'b0, w_rdata[35:24]};
    assign w_sum_y = {1'b0, w_rdata[23:12]} + {1'b0, w_rdata[11:0]};

    assign o_ready = (r_state == S_IDLE) && !r_ovalid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_valid && o_ready) begin
                n_state = (i_func == FUNC_LOAD || w_outside || w_limit == '0)
                          ? S_DONE : S_READ;
            end
            S_READ: n_state = S_LINE;
            S_LINE: n_state = S_MUL;
            S_MUL:  if (r_pidx == 3'd5) n_state = S_EVAL;
            S_EVAL: n_state = w_hit ? S_DONE : ((r_line == 2'd3) ? S_CONT : S_MUL);
            S_CONT: n_state = (w_inside || (r_cnt + 1'b1 == w_limit)) ? S_DONE : S_READ;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_idx    <= '0;
            r_cnt    <= '0;
        end else begin
            r_state <= n_state;
            if (o_valid && i_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: if (i_valid && o_ready) begin
                    r_sx <= i_start_x; r_sy <= i_start_y;
                    r_ex <= i_end_x;   r_ey <= i_end_y;
                    r_idx <= '0;
                    r_cnt <= '0;
                    r_bslot <= '0;
                    r_status <= (i_func == FUNC_CHECK && w_outside) ? ST_OUTSIDE : ST_OK;
                end
                S_READ: ;
                S_LINE: begin
                    // ram data is ready: scale edges to q12.4
                    r_l  <= {w_rdata[47:36], 4'b0};
                    r_r  <= {w_rdata[35:24], 4'b0};
                    r_b  <= {w_rdata[23:12], 4'b0};
                    r_t  <= {w_rdata[11:0], 4'b0};
                    r_mx <= {w_sum_x[12:1], 4'b0};
                    r_my <= {w_sum_y[12:1], 4'b0};
                    r_line <= 2'd0;
                    r_pidx <= 3'd0;
                end
                S_MUL: begin
                    // one product per cycle, folded in on the following cycle
                    r_prod <= w_ma * w_mb;
                    r_pidx <= (r_pidx == 3'd5) ? 3'd0 : r_pidx + 3'd1;
                    if (r_pidx != 3'd0) begin
                        case (r_pidx)
                            3'd1, 3'd3, 3'd5: r_acc <= DW'(r_prod);
                            3'd2: r_den <= r_acc - DW'(r_prod);
                            default: r_sn <= r_acc - DW'(r_prod);
                        endcase
                    end
                end
                S_EVAL: ;
                S_CONT: begin
                    r_idx <= r_idx + 1'b1;
                    r_cnt <= r_cnt + 1'b1;
                    r_line <= 2'd0;
                    if (w_inside) begin
                        r_status <= ST_INSIDE;
                        r_bslot  <= 5'(r_cnt);
                    end
                end
                S_DONE: r_ovalid <= 1'b1;
                default: ;
            endcase
            if (r_state == S_EVAL) begin
                if (w_hit) begin
                    r_status <= ST_CROSS;
                    r_bslot  <= 5'(r_cnt);
                end
                r_line <= r_line + 2'd1;
            end
        end
    end

    assign o_valid         = r_ovalid;
    assign o_status        = r_status;
    assign o_blocking_slot = r_bslot;

    `ASSERT_IMPL(a_ready_only_idle, i_clk, i_rst_n, o_ready, r_state == S_IDLE)
    `ASSERT_NEXT(a_done_gives_valid, i_clk, i_rst_n, r_state == S_DONE, o_valid)
    `ASSERT_IMPL(a_cnt_in_range, i_clk, i_rst_n, r_state == S_CONT, r_cnt < w_limit)
endmodule

// ===== sim/segment_obstacle_collision_check_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// segment_obstacle_collision_check_top_tb
// loads rectangular obstacles and checks query segments against them; every
// result is compared with an in-bench collision predictor or a given expectation,
// under random request gaps and result back-pressure, across several area and count settings
// ----------------------------------------------------------------------------
module segment_obstacle_collision_check_top_tb;
    import socc_pkg::*;

    localparam int N_SLOTS = 32;

    typedef struct {
        logic        func;
        logic [4:0]  slot;
        logic [11:0] rl, rr, rt, rb;
        logic [15:0] sx, sy, ex, ey;
    } t_req;

    typedef struct {
        t_status    status;
        logic [4:0] slot;
    } t_res;

    typedef struct {
        bit       is_cfg;
        t_cfg_idx cfg_idx;
        int       cfg_data;
        t_req     req;
        bit       has_exp;
        t_res     exp;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [11:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic        i_func;
    logic [4:0]  i_slot;
    logic [11:0] i_rect_left, i_rect_right, i_rect_top, i_rect_bottom;
    logic [15:0] i_start_x, i_start_y, i_end_x, i_end_y;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_status;
    logic [4:0]  o_blocking_slot;

    segment_obstacle_collision_check_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_func          (i_func),
        .i_slot          (i_slot),
        .i_rect_left     (i_rect_left),
        .i_rect_right    (i_rect_right),
        .i_rect_top      (i_rect_top),
        .i_rect_bottom   (i_rect_bottom),
        .i_start_x       (i_start_x),
        .i_start_y       (i_start_y),
        .i_end_x         (i_end_x),
        .i_end_y         (i_end_y),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_blocking_slot (o_blocking_slot)
    );

    // predictor copy of the obstacle table, ordered edges in whole pixels
    longint obst_l [N_SLOTS];
    longint obst_r [N_SLOTS];
    longint obst_b [N_SLOTS];
    longint obst_t [N_SLOTS];
    longint area_w_px;
    longint area_h_px;
    int     walk_count;

    t_res   pending_results[$];
    t_row   directed_rows[$];
    int     fail_count;
    int     load_count;
    int     query_count;
    int     status_seen [4];
    int     cfg_writes;
    bit     no_idle;

    // clock, 20 ns period
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // watchdog, far above the slowest legal run
    initial begin
        #200_000_000;
        $display("timeout with %0d results still pending", pending_results.size());
        $display("segment_obstacle_collision_check_top_tb: FAIL");
        $finish;
    end

    // exact segment crossing test, ends included, parallel lines never cross
    function automatic bit segs_cross(longint ax, longint ay, longint bx, longint by,
                                      longint cx, longint cy, longint dx, longint dy);
        longint ux, uy, vx, vy, wx, wy, den, sn, tn;
        ux = bx - ax; uy = by - ay;
        vx = dx - cx; vy = dy - cy;
        wx = ax - cx; wy = ay - cy;
        den = ux * vy - vx * uy;
        sn = ux * wy - uy * wx;
        tn = vx * wy - vy * wx;
        if (den == 0) return 1'b0;
        if (den < 0) begin
            den = -den; sn = -sn; tn = -tn;
        end
        return (sn >= 0) && (sn <= den) && (tn >= 0) && (tn <= den);
    endfunction

    // applies one request to the predictor state and returns its result
    function automatic t_res predict_collision(t_req r);
        t_res   res;
        longint sx, sy, ex, ey, l, rt, b, t, mx, my;
        int     n;
        res.status = ST_OK;
        res.slot   = '0;
        if (r.func == FUNC_LOAD) begin
            obst_l[r.slot] = (r.rl < r.rr) ? r.rl : r.rr;
            obst_r[r.slot] = (r.rl < r.rr) ? r.rr : r.rl;
            obst_b[r.slot] = (r.rt < r.rb) ? r.rt : r.rb;
            obst_t[r.slot] = (r.rt < r.rb) ? r.rb : r.rt;
            return res;
        end
        sx = r.sx; sy = r.sy; ex = r.ex; ey = r.ey;
        if (ex > area_w_px * 16 || ey > area_h_px * 16) begin
            res.status = ST_OUTSIDE;
            return res;
        end
        n = (walk_count > N_SLOTS) ? N_SLOTS : walk_count;
        for (int i = 0; i < n; i++) begin
            l  = obst_l[i] * 16; rt = obst_r[i] * 16;
            b  = obst_b[i] * 16; t  = obst_t[i] * 16;
            my = ((obst_b[i] + obst_t[i]) / 2) * 16;
            mx = ((obst_l[i] + obst_r[i]) / 2) * 16;
            if (segs_cross(l, b, rt, t, sx, sy, ex, ey) ||
                segs_cross(l, t, rt, b, sx, sy, ex, ey) ||
                segs_cross(l, my, rt, my, sx, sy, ex, ey) ||
                segs_cross(mx, b, mx, t, sx, sy, ex, ey)) begin
                res.status = ST_CROSS;
                res.slot   = i[4:0];
                return res;
            end
            if (ex >= l && ex <= rt && ey >= b && ey <= t) begin
                res.status = ST_INSIDE;
                res.slot   = i[4:0];
                return res;
            end
        end
        return res;
    endfunction

    function automatic t_req mk_load(int slot, int rl, int rr, int rt, int rb);
        t_req r;
        r.func = FUNC_LOAD; r.slot = slot[4:0];
        r.rl = rl[11:0]; r.rr = rr[11:0]; r.rt = rt[11:0]; r.rb = rb[11:0];
        // start and end are don't-care on a load
        r.sx = $urandom; r.sy = $urandom; r.ex = $urandom; r.ey = $urandom;
        return r;
    endfunction

    function automatic t_req mk_query(int sx, int sy, int ex, int ey);
        t_req r;
        // slot and rect are don't-care on a query
        r.func = FUNC_CHECK; r.slot = $urandom;
        r.rl = $urandom; r.rr = $urandom; r.rt = $urandom; r.rb = $urandom;
        r.sx = sx[15:0]; r.sy = sy[15:0]; r.ex = ex[15:0]; r.ey = ey[15:0];
        return r;
    endfunction

    function automatic void add_req(t_req r, bit has_exp = 0,
                                    t_status st = ST_OK, int slot = 0);
        t_row row;
        row.is_cfg = 0; row.req = r; row.has_exp = has_exp;
        row.exp.status = st; row.exp.slot = slot[4:0];
        directed_rows.push_back(row);
    endfunction

    function automatic void add_cfg(t_cfg_idx idx, int data);
        t_row row;
        row.is_cfg = 1; row.cfg_idx = idx; row.cfg_data = data; row.has_exp = 0;
        directed_rows.push_back(row);
    endfunction

    // one request: optional idle gap, then hold valid until accepted; valid is left
    // high after acceptance and the next call or a drop decides its next value
    task automatic send_req(t_req r, bit has_exp, t_res typed);
        int   gap;
        t_res p;
        gap = (!no_idle && $urandom_range(99) < 34) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_func        <= r.func;
        i_slot        <= r.slot;
        i_rect_left   <= r.rl;
        i_rect_right  <= r.rr;
        i_rect_top    <= r.rt;
        i_rect_bottom <= r.rb;
        i_start_x     <= r.sx;
        i_start_y     <= r.sy;
        i_end_x       <= r.ex;
        i_end_y       <= r.ey;
        do @(posedge i_clk); while (!o_ready);
        p = predict_collision(r);
        pending_results.push_back(has_exp ? typed : p);
        if (r.func == FUNC_LOAD) load_count++;
        else query_count++;
    endtask

    // register write, only once every pending result has arrived
    task automatic write_cfg(t_cfg_idx idx, int data);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data[11:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_AREA_W: area_w_px  = data & 12'hfff;
            CFG_AREA_H: area_h_px  = data & 12'hfff;
            CFG_COUNT:  walk_count = data & 6'h3f;
            default: ;
        endcase
        cfg_writes++;
        @(posedge i_clk);
    endtask

    // random request: mostly well-formed segments near the obstacles
    function automatic t_req rand_req();
        int x0, y0;
        if ($urandom_range(99) < 15) begin
            if ($urandom_range(99) < 80) begin
                x0 = $urandom_range(0, 1000);
                y0 = $urandom_range(0, 1000);
                return mk_load($urandom_range(0, N_SLOTS - 1), x0, x0 + $urandom_range(0, 120),
                               y0 + $urandom_range(0, 120), y0);
            end
            return mk_load($urandom_range(0, N_SLOTS - 1), $urandom_range(0, 4095),
                           $urandom_range(0, 4095), $urandom_range(0, 4095),
                           $urandom_range(0, 4095));
        end
        if ($urandom_range(99) < 70) begin
            x0 = $urandom_range(0, 1150 * 16);
            y0 = $urandom_range(0, 1150 * 16);
            return mk_query(x0, y0, x0 + $urandom_range(0, 4000) - 2000,
                            y0 + $urandom_range(0, 4000) - 2000);
        end
        return mk_query($urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom_range(0, 65535), $urandom_range(0, 65535));
    endfunction

    // result side: random back-pressure, one long hold-off, compare in order
    initial begin
        int   results_seen;
        int   hold_left;
        bit   held;
        t_res want;
        results_seen = 0;
        hold_left    = 0;
        held         = 0;
        i_ready      = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result status %0d slot %0d",
                                 o_status, o_blocking_slot);
                end else begin
                    want = pending_results.pop_front();
                    status_seen[want.status]++;
                    if (o_status !== want.status || o_blocking_slot !== want.slot) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: status exp %0d got %0d, slot exp %0d got %0d",
                                     want.status, o_status, want.slot, o_blocking_slot);
                    end
                end
            end
            // stall the output long enough that the request side backs up
            if (hold_left > 0) hold_left--;
            else if (!held && results_seen == 100) begin
                held      = 1;
                hold_left = 500;
            end
            i_ready <= i_rst_n && (hold_left == 0) && (no_idle || $urandom_range(99) >= 34);
        end
    end

    // request side and phases
    initial begin
        t_res dummy;
        int   wait_cycles;
        dummy.status = ST_OK; dummy.slot = '0;
        fail_count = 0; load_count = 0; query_count = 0; cfg_writes = 0;
        no_idle = 0;
        foreach (status_seen[i]) status_seen[i] = 0;
        foreach (obst_l[i]) begin
            obst_l[i] = 0; obst_r[i] = 0; obst_b[i] = 0; obst_t[i] = 0;
        end
        area_w_px = 4095; area_h_px = 4095; walk_count = 0;

        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        i_valid = 1'b0; i_func = FUNC_LOAD; i_slot = '0;
        i_rect_left = '0; i_rect_right = '0; i_rect_top = '0; i_rect_bottom = '0;
        i_start_x = '0; i_start_y = '0; i_end_x = '0; i_end_y = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // after reset: count is zero and the area is the full 4095 square
        add_req(mk_query(0, 0, 0, 0), 1, ST_OK, 0);
        add_req(mk_query(0, 0, 65535, 0), 1, ST_OUTSIDE, 0);
        add_req(mk_query(65535, 65535, 0, 65535), 1, ST_OUTSIDE, 0);
        add_req(mk_query(65535, 65535, 65520, 65520), 1, ST_OK, 0);
        // every slot gets a tiny obstacle in the far corner so none is unwritten
        for (int i = 0; i < N_SLOTS; i++)
            add_req(mk_load(i, 3700 + i * 12, 3703 + i * 12, 3700 + i * 12, 3703 + i * 12),
                    1, ST_OK, 0);
        // edges given in reverse order, and the full-range extreme
        add_req(mk_load(0, 200, 100, 300, 100), 1, ST_OK, 0);
        add_req(mk_load(1, 500, 600, 500, 600), 1, ST_OK, 0);
        add_req(mk_load(31, 4095, 0, 0, 4095), 1, ST_OK, 0);
        add_cfg(CFG_COUNT, 2);
        add_req(mk_query(50 * 16, 50 * 16, 250 * 16, 350 * 16));       // through slot 0
        add_req(mk_query(8801, 8805, 8803, 8805));                     // ends inside slot 1
        add_req(mk_query(900 * 16, 900 * 16, 900 * 16, 900 * 16));     // degenerate, free
        add_req(mk_query(550 * 16, 550 * 16, 550 * 16, 550 * 16));     // point on both midlines
        add_req(mk_query(400 * 16, 500 * 16, 500 * 16, 500 * 16));     // touches a corner
        add_req(mk_query(0, 2000 * 16, 4000 * 16, 2000 * 16));         // misses both
        add_cfg(CFG_COUNT, 63);                                        // clamps to all slots
        add_req(mk_query(2000 * 16, 100, 2000 * 16, 65520));
        add_req(mk_query(0, 0, 65520, 65520));
        add_cfg(CFG_COUNT, 0);
        add_cfg(CFG_AREA_W, 0);
        add_cfg(CFG_AREA_H, 0);
        add_req(mk_query(100, 100, 0, 0), 1, ST_OK, 0);
        add_req(mk_query(0, 0, 1, 0), 1, ST_OUTSIDE, 0);
        add_req(mk_query(0, 0, 0, 1), 1, ST_OUTSIDE, 0);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg)
                write_cfg(directed_rows[i].cfg_idx, directed_rows[i].cfg_data);
            else
                send_req(directed_rows[i].req, directed_rows[i].has_exp,
                         directed_rows[i].exp);
        end

        // random phases: full area, clamp, tiny area, then random settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_cfg(CFG_AREA_W, 4095); write_cfg(CFG_AREA_H, 4095);
                         write_cfg(CFG_COUNT, 32); end
                1: write_cfg(CFG_COUNT, 63);
                2: begin write_cfg(CFG_AREA_W, 300); write_cfg(CFG_AREA_H, 1200);
                         write_cfg(CFG_COUNT, 1); end
                default: begin
                    write_cfg(CFG_AREA_W, $urandom_range(600, 4095));
                    write_cfg(CFG_AREA_H, $urandom_range(600, 4095));
                    write_cfg(CFG_COUNT, $urandom_range(0, 63));
                end
            endcase
            // one phase runs with no idling on either side
            no_idle = (ph == 3);
            for (int k = 0; k < 150; k++)
                send_req(rand_req(), 0, dummy);
        end
        no_idle = 0;
        i_valid <= 1'b0;

        // drain, then let the block settle
        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 200000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        if (pending_results.size() != 0) begin
            fail_count++;
            $display("%0d results never arrived", pending_results.size());
        end
        repeat (300) @(posedge i_clk);

        $display("covered %0d loads and %0d segment checks over %0d register writes",
                 load_count, query_count, cfg_writes);
        $display("outcomes: clear %0d, outside %0d, crossing %0d, end inside %0d; %0d failures",
                 status_seen[ST_OK], status_seen[ST_OUTSIDE], status_seen[ST_CROSS],
                 status_seen[ST_INSIDE], fail_count);
        if (fail_count == 0)
            $display("segment_obstacle_collision_check_top_tb: PASS");
        else
            $display("segment_obstacle_collision_check_top_tb: FAIL");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+design
design/socc_pkg.sv
design/socc_ram.sv
design/segment_obstacle_collision_check_top.sv
sim/segment_obstacle_collision_check_top_tb.sv
